// ===== rtl/core/sha_pkg.sv =====
// Package for the SHA-256 stream hasher: types, round constants, helpers.
// No dependencies.
package sha_pkg;
   localparam int BLOCK_BYTES = 64;
   localparam int LEN_POS = 56;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [1:0]  word_index;
      logic        digest_last;
   } rsp_type;

   // front-end command: a word of the block or an order to compress
   typedef struct packed {
      logic [31:0] word;
      logic [3:0]  index;
      logic        compress;
      logic        finish;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_LOAD, BK_ROUND, BK_ADD, BK_EMIT
   } back_state_type;

   typedef enum logic [1:0] {
      FR_BYTES, FR_ZERO, FR_LEN_HI, FR_LEN_LO
   } front_state_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
         32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
         32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
         32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
         32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
         32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
         32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
         32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
         32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[i];
   endfunction

   localparam logic [255:0] INIT_H = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction
endpackage

// ===== rtl/core/sha_stream_if.sv =====
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; payload type is a parameter.
interface sha_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/sha_front.sv =====
// Front end: packs bytes into 32-bit block words, inserts padding and length.
// Depends on sha_pkg.
module sha_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sha_pkg::req_type  in_data,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output sha_pkg::cmd_type  cmd_data
);
   import sha_pkg::*;

   front_state_type state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] total_ff, total_in;
   logic [23:0] part_ff, part_in;
   logic        two_ff, two_in;    // padding spills into an extra block
   logic        pad_ff, pad_in;    // pad byte still owed at the next word

   logic [31:0] word;
   logic [63:0] bits;

   assign bits = {total_ff, 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_BYTES;
         fill_ff <= '0;
         total_ff <= '0;
         two_ff <= 1'b0;
         pad_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         total_ff <= total_in;
         two_ff <= two_in;
         pad_ff <= pad_in;
      end
      part_ff <= part_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_BYTES: if (in_valid && in_ready && in_data.last_byte) state_in = FR_ZERO;
         FR_ZERO:  if (!two_ff && ((fill_ff[5:2] == 4'd14) ||
                                   (cmd_ready && fill_ff[5:2] == 4'd13))) state_in = FR_LEN_HI;
         FR_LEN_HI: if (cmd_ready) state_in = FR_LEN_LO;
         FR_LEN_LO: if (cmd_ready) state_in = FR_BYTES;
         default: state_in = FR_BYTES;
      endcase
   end

   always_comb begin
      logic [5:0] f;
      logic [23:0] p;
      logic [7:0] b;
      fill_in = fill_ff;
      total_in = total_ff;
      part_in = part_ff;
      two_in = two_ff;
      pad_in = pad_ff;
      in_ready = 1'b0;
      cmd_valid = 1'b0;
      word = '0;
      f = fill_ff;
      p = part_ff;
      b = in_data.data_byte;
      cmd_data = '{word: '0, index: fill_ff[5:2], compress: 1'b0, finish: 1'b0};
      unique case (state_ff)
         FR_BYTES: begin
            // a word issues when its fourth byte (or the pad byte) lands
            in_ready = cmd_ready || !in_data.byte_present && !in_data.last_byte ||
                       (fill_ff[1:0] != 2'd3 && !in_data.last_byte);
            if (in_valid && in_data.byte_present) begin
               unique case (f[1:0])
                  2'd0: p = {b, 16'h0};
                  2'd1: p = {p[23:16], b, 8'h0};
                  2'd2: p = {p[23:8], b};
                  default: ;
               endcase
               if (f[1:0] == 2'd3) begin
                  cmd_valid = 1'b1;
                  cmd_data.word = {p, b};
                  cmd_data.compress = (f == 6'd63);
               end
               f = f + 6'd1;
               if (in_ready) total_in = total_ff + 61'd1;
            end
            if (in_valid && in_data.last_byte && cmd_valid) begin
               // the byte closed a word: the pad byte opens the next one
               if (in_ready) begin
                  pad_in = 1'b1;
                  two_in = (f[5:2] >= 4'd14);
               end
            end else if (in_valid && in_data.last_byte) begin
               // pad byte goes into the current word now
               unique case (f[1:0])
                  2'd0: word = {PAD_BYTE, 24'h0};
                  2'd1: word = {p[23:16], PAD_BYTE, 16'h0};
                  2'd2: word = {p[23:8], PAD_BYTE, 8'h0};
                  default: word = {p, PAD_BYTE};
               endcase
               cmd_valid = 1'b1;
               cmd_data.word = word;
               cmd_data.index = f[5:2];
               cmd_data.compress = (f[5:2] == 4'd15);
               two_in = (f[5:2] == 4'd14);
               f = {f[5:2] + 4'd1, 2'b00};
            end
            if (in_valid && in_ready) begin
               fill_in = f;
               part_in = p;
            end
         end
         FR_ZERO: begin
            if (fill_ff[5:2] == 4'd14 && !two_ff) begin
               cmd_valid = 1'b0;
            end else begin
               cmd_valid = 1'b1;
            end
            cmd_data.word = pad_ff ? {PAD_BYTE, 24'h0} : '0;
            cmd_data.compress = (fill_ff[5:2] == 4'd15);
            if (fill_ff == 6'd0 && !two_ff && fill_ff[5:2] != 4'd14) cmd_valid = 1'b1;
            if (cmd_ready && cmd_valid) begin
               fill_in = {fill_ff[5:2] + 4'd1, 2'b00};
               pad_in = 1'b0;
               if (fill_ff[5:2] == 4'd15) two_in = 1'b0;
            end
         end
         FR_LEN_HI: begin
            cmd_valid = 1'b1;
            cmd_data.index = 4'd14;
            cmd_data.word = bits[63:32];
         end
         FR_LEN_LO: begin
            cmd_valid = 1'b1;
            cmd_data.index = 4'd15;
            cmd_data.word = bits[31:0];
            cmd_data.compress = 1'b1;
            cmd_data.finish = 1'b1;
            if (cmd_ready) begin
               fill_in = '0;
               total_in = '0;
            end
         end
         default: ;
      endcase
   end
endmodule

// ===== rtl/core/sha_queue.sv =====
// Short FIFO between front end and compression core.
// Depends on sha_pkg.
module sha_queue #(
   parameter int DEPTH = sha_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  sha_pkg::cmd_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output sha_pkg::cmd_type out_data
);
   import sha_pkg::*;
   localparam int AW = $clog2(DEPTH);

   cmd_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [AW:0]     cnt_ff;
   logic            push, pop;

   assign in_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (pop) rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= (AW+1)'(DEPTH))
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> !out_valid) else $error("empty queue shows valid");
endmodule

// ===== rtl/core/sha_back.sv =====
// Compression core: loads 16 words, runs 64 rounds, emits digest words.
// Depends on sha_pkg.
module sha_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  sha_pkg::cmd_type cmd_data,
   output logic             out_valid,
   input  logic             out_ready,
   output sha_pkg::rsp_type out_data
);
   import sha_pkg::*;

   back_state_type state_ff, state_in;
   logic [31:0] w_ff [16];
   logic [31:0] h_ff [8], v_ff [8];
   logic [5:0]  rnd_ff;
   logic [1:0]  widx_ff;
   logic        fin_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_LOAD:  if (cmd_valid && cmd_data.compress) state_in = BK_ROUND;
         BK_ROUND: if (rnd_ff == 6'd63) state_in = BK_ADD;
         BK_ADD:   state_in = fin_ff ? BK_EMIT : BK_LOAD;
         BK_EMIT:  if (out_ready && widx_ff == 2'd3) state_in = BK_LOAD;
         default:  state_in = BK_LOAD;
      endcase
   end

   always_comb begin
      cmd_ready = (state_ff == BK_LOAD);
      out_valid = (state_ff == BK_EMIT);
      out_data.digest_word = {h_ff[{widx_ff, 1'b0}], h_ff[{widx_ff, 1'b1}]};
      out_data.word_index = widx_ff;
      out_data.digest_last = (widx_ff == 2'd3);
   end

   logic [31:0] wt, s0, s1, wn, t1, t2, e, a;
   always_comb begin
      wt = w_ff[0];
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = w_ff[0] + s0 + w_ff[9] + s1;
      e = v_ff[4];
      a = v_ff[0];
      t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
           ((e & v_ff[5]) ^ (~e & v_ff[6])) + round_k(rnd_ff) + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
           ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_LOAD;
         rnd_ff <= '0;
         widx_ff <= '0;
         fin_ff <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[255-32*i -: 32];
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            BK_LOAD: if (cmd_valid) begin
               w_ff[cmd_data.index] <= cmd_data.word;
               fin_ff <= cmd_data.finish;
               rnd_ff <= '0;
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
            end
            BK_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= wn;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               rnd_ff <= rnd_ff + 6'd1;
            end
            BK_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               widx_ff <= '0;
            end
            BK_EMIT: if (out_ready) begin
               widx_ff <= widx_ff + 2'd1;
               if (widx_ff == 2'd3) begin
                  for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[255-32*i -: 32];
               end
            end
            default: ;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_ROUND && rnd_ff == 6'd63) |=> state_ff == BK_ADD)
      else $error("round count slip");
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !cmd_ready) else $error("load during emit");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> $stable(widx_ff)) else $error("index moved under stall");
endmodule

// ===== rtl/core/sha256_stream_hasher.sv =====
// SHA-256 stream hasher top level: front end, command queue, compression core.
// Depends on sha_pkg, sha_stream_if, sha_front, sha_queue, sha_back.
//
// Takes at most one message byte per word on req; a word with last_byte set
// ends the message and four 64-bit digest words follow on rsp, word_index 0
// first. Each block holds the core through its load, round and add states.
// While the rounds run the four-word queue lets the front end take the first
// 19 bytes of the next block; the rest arrive one per cycle during the load
// while the source keeps up, so a long message is paced by the single round
// unit and the byte rate. After the last word the front end issues the zero
// and length words as the queue takes them, the core runs one or two more
// blocks and presents the four digest words, one per cycle while rsp is ready.
module sha256_stream_hasher #(
   parameter int QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
   input logic clock,
   input logic reset,
   sha_stream_if.sink   req,
   sha_stream_if.source rsp
);
   import sha_pkg::*;

   logic    f_valid, f_ready, q_valid, q_ready;
   cmd_type f_cmd, q_cmd;

   sha_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.payload),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_cmd));

   sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_cmd));

   sha_back u_back (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_cmd),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.payload));
endmodule

// ===== tb/sha_tb_pkg.sv =====
// Testbench-side helpers for the SHA-256 stream hasher bench.
// Depends on sha_pkg, which it imports; holds the expected digest word type.
`timescale 1ns / 1ps
package sha_tb_pkg;
   import sha_pkg::*;

   typedef struct {
      logic [63:0] digest_word;
      logic [1:0]  word_index;
      logic        digest_last;
   } digest_exp_type;
endpackage

// ===== tb/testbench.sv =====
// Bench for sha256_stream_hasher: random byte streams against an in-bench SHA-256 model.
// Depends on sha_pkg, sha_stream_if, sha_tb_pkg and the RTL top level.
`timescale 1ns / 1ps
module testbench;
   import sha_pkg::*;
   import sha_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count = 0;
   int   messages_done = 0;

   sha_stream_if #(.payload_type(req_type)) req (clock);
   sha_stream_if #(.payload_type(rsp_type)) rsp (clock);

   sha256_stream_hasher dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------- hash model ----------------
   logic [31:0] sum_h [8];
   logic [7:0]  buf_bytes [64];
   int          fill_n;
   logic [60:0] total_n;
   req_type        pending_words [$];
   digest_exp_type digest_q [$];

   localparam logic [31:0] K_TAB [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_hash();
      logic [255:0] iv;
      iv = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      for (int i = 0; i < 8; i++) sum_h[i] = iv[255 - 32*i -: 32];
      fill_n = 0;
      total_n = '0;
   endtask

   task automatic compress_buf();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {buf_bytes[4*i], buf_bytes[4*i+1], buf_bytes[4*i+2], buf_bytes[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = sum_h[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int j = 7; j > 0; j--) v[j] = v[j-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) sum_h[i] += v[i];
   endtask

   task automatic hash_word(req_type it);
      logic [63:0] bits;
      digest_exp_type e;
      if (it.byte_present) begin
         buf_bytes[fill_n] = it.data_byte;
         fill_n++;
         total_n++;
         if (fill_n == 64) begin
            compress_buf();
            fill_n = 0;
         end
      end
      if (!it.last_byte) return;
      bits = {total_n, 3'b000};
      buf_bytes[fill_n] = PAD_BYTE;
      fill_n++;
      if (fill_n > LEN_POS) begin
         for (int i = fill_n; i < 64; i++) buf_bytes[i] = 8'h00;
         compress_buf();
         fill_n = 0;
      end
      for (int i = fill_n; i < LEN_POS; i++) buf_bytes[i] = 8'h00;
      for (int i = 0; i < 8; i++) buf_bytes[LEN_POS + i] = bits[63 - 8*i -: 8];
      compress_buf();
      for (int i = 0; i < 4; i++) begin
         e.digest_word = {sum_h[2*i], sum_h[2*i+1]};
         e.word_index = i[1:0];
         e.digest_last = (i == 3);
         digest_q = {digest_q, e};
      end
      restart_hash();
   endtask

   // ---------------- stimulus ----------------
   function automatic req_type mk(logic [7:0] b, logic p, logic l);
      req_type r;
      r.data_byte = b;
      r.byte_present = p;
      r.last_byte = l;
      return r;
   endfunction

   task automatic add_word(req_type r);
      pending_words = {pending_words, r};
   endtask

   task automatic push_message(int len, logic tail_empty);
      for (int i = 0; i < len; i++) begin
         // occasional empty word mid-message, with junk on the data lines
         if ($urandom_range(0, 15) == 0)
            add_word(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
         add_word(mk(8'($urandom_range(0, 255)), 1'b1, !tail_empty && i == len - 1));
      end
      if (tail_empty || len == 0)
         add_word(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
   endtask

   logic stim_done = 1'b0;

   initial begin
      int lens [3];
      lens = '{52, 56, 60};
      // directed: empty message, short messages, extreme byte values
      add_word(mk(8'hff, 1'b0, 1'b1));
      add_word(mk(8'h00, 1'b1, 1'b0));
      add_word(mk(8'hff, 1'b1, 1'b0));
      add_word(mk(8'h5a, 1'b0, 1'b0));
      add_word(mk(8'h80, 1'b1, 1'b1));
      add_word(mk(8'h01, 1'b1, 1'b0));
      add_word(mk(8'h00, 1'b0, 1'b1));
      // pad byte in words 13, 14 and 15 of the block
      foreach (lens[i]) push_message(lens[i], 1'($urandom_range(0, 1)));
      // short random messages to round off the run
      while (pending_words.size() < 180) begin
         int n;
         n = $urandom_range(0, 8);
         push_message(n, 1'($urandom_range(0, 1)));
      end
      stim_done = 1'b1;
   end

   // ---------------- driver ----------------
   int     send_gap = 0;
   int     recv_gap = 0;
   int     words_in = 0;
   logic   req_fire = 1'b0;
   req_type cur;

   initial begin
      req.valid = 1'b0;
      req.payload = '0;
      rsp.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
   end

   // input words are taken at the rising edge
   always @(posedge clock) begin
      req_fire = !reset && req.valid && req.ready;
      if (req_fire) begin
         hash_word(req.payload);
         words_in++;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire) begin
            send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 4) == 0) send_gap = 0;
         end
         if (req.valid && !req_fire) begin
            // hold current word
         end else if (send_gap > 0) begin
            send_gap--;
            req.valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            cur = pending_words.pop_front();
            req.payload <= cur;
            req.valid <= 1'b1;
         end else begin
            req.valid <= 1'b0;
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         digest_exp_type e;
         if (digest_q.size() == 0) begin
            $error("digest word with nothing expected: %h", rsp.payload.digest_word);
            error_count++;
         end else begin
            e = digest_q.pop_front();
            if (rsp.payload.digest_word !== e.digest_word) begin
               $error("digest_word: expected %h, got %h", e.digest_word,
                      rsp.payload.digest_word);
               error_count++;
            end
            if (rsp.payload.word_index !== e.word_index) begin
               $error("word_index: expected %0d, got %0d", e.word_index,
                      rsp.payload.word_index);
               error_count++;
            end
            if (rsp.payload.digest_last !== e.digest_last) begin
               $error("digest_last: expected %0d, got %0d", e.digest_last,
                      rsp.payload.digest_last);
               error_count++;
            end
            if (e.digest_last) messages_done++;
         end
         recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end
   end

   // ---------------- end of run ----------------
   initial begin
      restart_hash();
      wait (stim_done);
      @(posedge clock);
      wait (pending_words.size() == 0 && !req.valid && !reset);
      wait (digest_q.size() == 0);
      repeat (300) @(posedge clock);
      $display("hashed %0d messages from %0d input words, stalls on both sides",
               messages_done, words_in);
      if (error_count == 0 && digest_q.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout");
      $display("testbench: done, errors");
      $finish;
   end
endmodule

// ===== sha256_stream_hasher.f =====
rtl/core/sha_pkg.sv
rtl/core/sha_stream_if.sv
rtl/core/sha_front.sv
rtl/core/sha_queue.sv
rtl/core/sha_back.sv
rtl/core/sha256_stream_hasher.sv
tb/sha_tb_pkg.sv
tb/testbench.sv
